>>> hw/rtl/mocal_pkg.sv
// Package for the magnetometer offset calibration block.
// Holds field widths, register indexes, reset values and the per-axis update function.
// Used by magnetometer_offset_calibration; depends on nothing else.
`default_nettype none

package mocal_pkg;

    // Field widths.
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned VAL_W   = 12;
    localparam int unsigned CORR_W  = 13;
    localparam int unsigned LIM_W   = 11;
    localparam int unsigned SPAN_W  = 12;
    localparam int unsigned AXES    = 3;

    // Stream payload widths (fields packed lowest first, padded to whole bytes).
    localparam int unsigned IN_DATA_W  = AXES * RAW_W;
    localparam int unsigned OUT_BITS   = AXES * (CORR_W + VAL_W + 1);
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REJECT_LIMIT = 2'd0,
        CFG_FREEZE_SPAN  = 2'd1
    } t_cfg_index;

    localparam logic [LIM_W-1:0]  REJECT_LIMIT_RST = LIM_W'(120);
    localparam logic [SPAN_W-1:0] FREEZE_SPAN_RST  = SPAN_W'(120);

    // Per-axis tracking state.
    typedef struct packed {
        logic signed [VAL_W-1:0] last;
        logic signed [VAL_W-1:0] high;
        logic signed [VAL_W-1:0] low;
    } t_axis_state;

    // Per-axis outcome of one sample: new state plus result fields.
    typedef struct packed {
        t_axis_state              st;
        logic signed [CORR_W-1:0] corr;
        logic signed [VAL_W-1:0]  off;
        logic                     frozen;
    } t_axis_res;

    // One axis: spike rejection, min/max tracking, offset and correction.
    function automatic t_axis_res axis_step(
        input logic signed [RAW_W-1:0] raw,
        input t_axis_state             cur,
        input logic [LIM_W-1:0]        lim,
        input logic [SPAN_W-1:0]       fs
    );
        logic signed [RAW_W:0]    r_ext;
        logic signed [RAW_W:0]    lim_ext;
        logic signed [RAW_W:0]    lim_neg;
        logic signed [CORR_W-1:0] fs_ext;
        logic signed [CORR_W-1:0] span_old;
        logic signed [CORR_W-1:0] span_new;
        logic signed [CORR_W-1:0] sum;
        logic signed [CORR_W-1:0] half;
        logic signed [VAL_W-1:0]  rv;
        logic signed [VAL_W-1:0]  used;
        logic                     in_rng;
        logic                     track;
        t_axis_res                res;

        r_ext    = $signed({raw[RAW_W-1], raw});
        lim_ext  = $signed({{(RAW_W + 1 - LIM_W){1'b0}}, lim});
        lim_neg  = -lim_ext;
        in_rng   = (r_ext <= lim_ext) && (r_ext >= lim_neg);
        rv       = raw[VAL_W-1:0];
        fs_ext   = $signed({1'b0, fs});
        span_old = $signed({cur.high[VAL_W-1], cur.high}) - $signed({cur.low[VAL_W-1], cur.low});
        track    = span_old < fs_ext;
        used     = in_rng ? rv : cur.last;

        // Tracking update for an accepted reading on an unfrozen axis.
        res.st = cur;
        if (in_rng && track) begin
            res.st.last = rv;
            if (rv > cur.high) begin
                res.st.high = rv;
            end
            if (rv < cur.low) begin
                res.st.low = rv;
            end
        end

        // Offset is the midpoint, rounded toward zero.
        sum  = $signed({res.st.high[VAL_W-1], res.st.high})
             + $signed({res.st.low[VAL_W-1], res.st.low});
        half = (sum + $signed({{(CORR_W-1){1'b0}}, sum[CORR_W-1]})) >>> 1;
        res.off = half[VAL_W-1:0];

        res.corr = $signed({used[VAL_W-1], used}) - $signed({res.off[VAL_W-1], res.off});
        span_new = $signed({res.st.high[VAL_W-1], res.st.high})
                 - $signed({res.st.low[VAL_W-1], res.st.low});
        res.frozen = !(span_new < fs_ext);
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/magnetometer_offset_calibration.sv
// An accepted sample passes through the input register and then the result register; the per-axis
// compare, min/max and subtract are combinational; one sample per cycle unless the output stalls.
// The tracking state is read and written in the same single update stage, so samples chain freely.
// Reset (synchronous, active low) clears last reading, max and min of all axes to zero,
// loads both configuration registers with 120 and empties both pipeline registers.
// Top level of the magnetometer hard-iron offset calibration; depends on mocal_pkg.
`default_nettype none

module magnetometer_offset_calibration (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Sample stream in. tdata: raw_x, raw_y, raw_z (16 bits each).
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [mocal_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // Result stream out. tdata: corr_x, corr_y, corr_z (13 bits each),
    // off_x, off_y, off_z (12 bits each), frozen_x, frozen_y, frozen_z, two zero bits.
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic [mocal_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // Configuration writes.
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [mocal_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mocal_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mocal_pkg::*;

    logic [LIM_W-1:0]          r_reject_limit;
    logic [SPAN_W-1:0]         r_freeze_span;
    t_axis_state               r_state [AXES];
    logic                      r_in_valid;
    logic [IN_DATA_W-1:0]      r_in_data;
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    t_axis_res                 n_res   [AXES];
    logic [OUT_DATA_W-1:0]     n_out_data;
    logic                      adv;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject_limit <= REJECT_LIMIT_RST;
            r_freeze_span  <= FREEZE_SPAN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REJECT_LIMIT: r_reject_limit <= i_cfg_data[LIM_W-1:0];
                CFG_FREEZE_SPAN:  r_freeze_span  <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // The update stage fires when a sample is held and the result register can take it.
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // Per-axis calibration logic and result packing.
    always_comb begin
        n_out_data = '0;
        for (int a = 0; a < AXES; a++) begin
            n_res[a] = axis_step($signed(r_in_data[a*RAW_W +: RAW_W]), r_state[a],
                                 r_reject_limit, r_freeze_span);
            n_out_data[a*CORR_W +: CORR_W]                  = n_res[a].corr;
            n_out_data[AXES*CORR_W + a*VAL_W +: VAL_W]      = n_res[a].off;
            n_out_data[AXES*(CORR_W + VAL_W) + a]           = n_res[a].frozen;
        end
    end

    // Tracking state, updated once per transfer through the update stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_state[a] <= '0;
            end
        end else if (adv) begin
            for (int a = 0; a < AXES; a++) begin
                r_state[a] <= n_res[a].st;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A held sample behind a stalled result must block the input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while update stage is stalled");

    // The running max never drops below zero and the min never rises above zero.
    a_peak_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state[0].high[VAL_W-1] && !r_state[1].high[VAL_W-1] && !r_state[2].high[VAL_W-1]
        && (r_state[0].low[VAL_W-1] || (r_state[0].low == '0))
        && (r_state[1].low[VAL_W-1] || (r_state[1].low == '0))
        && (r_state[2].low[VAL_W-1] || (r_state[2].low == '0)))
        else $error("peak register left its sign range");

    // Tracking state changes only through the update stage.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_state[0]) && $stable(r_state[1]) && $stable(r_state[2])))
        else $error("tracking state changed without an update");

endmodule

`default_nettype wire

>>> tb/mocal_checker.sv
// Result checker for the magnetometer offset calibration block.
// Watches the sample, result and configuration channels, predicts every result
// and compares it field by field; depends on mocal_pkg.
`timescale 1ns / 1ps

module mocal_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    input  wire logic                                 i_s_axis_tready,
    input  wire logic [mocal_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  wire logic                                 i_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    input  wire logic [mocal_pkg::OUT_DATA_W-1:0]     i_m_axis_tdata,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 i_cfg_ready,
    input  wire logic [mocal_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mocal_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                        o_mismatch_count,
    output int                                        o_results_due
);
    import mocal_pkg::*;

    // Result layout: corr x/y/z, then off x/y/z, then frozen x/y/z.
    localparam int unsigned OFF_LSB    = AXES * CORR_W;
    localparam int unsigned FROZEN_LSB = OFF_LSB + AXES * VAL_W;

    // Own copy of the configuration and of the per-axis tracking state.
    logic [LIM_W-1:0]        spike_limit;
    logic [SPAN_W-1:0]       span_limit;
    logic signed [VAL_W-1:0] held_reading [AXES];
    logic signed [VAL_W-1:0] peak_max     [AXES];
    logic signed [VAL_W-1:0] peak_min     [AXES];

    // Corrected samples predicted but not yet seen on the result channel.
    logic [OUT_DATA_W-1:0]   corrected_samples_due [$];

    string axis_tag [AXES] = '{"x", "y", "z"};
    int                      mismatches = 0;
    int                      axis;
    int                      reading;
    int                      used;
    int                      offset;
    logic [OUT_DATA_W-1:0]   due;
    logic [OUT_DATA_W-1:0]   got;

    initial begin
        o_mismatch_count = 0;
        o_results_due    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spike_limit = REJECT_LIMIT_RST;
            span_limit  = FREEZE_SPAN_RST;
            for (axis = 0; axis < AXES; axis++) begin
                held_reading[axis] = '0;
                peak_max[axis]     = '0;
                peak_min[axis]     = '0;
            end
            corrected_samples_due.delete();
        end else begin
            // Register writes take effect for the samples that follow them.
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_REJECT_LIMIT: spike_limit = i_cfg_data[LIM_W-1:0];
                    CFG_FREEZE_SPAN:  span_limit  = i_cfg_data[SPAN_W-1:0];
                    default: ;
                endcase
            end

            // Predict the result of each accepted sample, one axis at a time.
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                due = '0;
                for (axis = 0; axis < AXES; axis++) begin
                    reading = int'($signed(i_s_axis_tdata[RAW_W*axis +: RAW_W]));
                    if (reading > int'(spike_limit) || reading < -int'(spike_limit)) begin
                        // A spike falls back to the last reading taken while tracking.
                        used = int'(held_reading[axis]);
                    end else begin
                        used = reading;
                        // Tracking only while the span held so far is below the limit.
                        if (int'(peak_max[axis]) - int'(peak_min[axis]) < int'(span_limit)) begin
                            held_reading[axis] = VAL_W'(reading);
                            if (reading > int'(peak_max[axis])) begin
                                peak_max[axis] = VAL_W'(reading);
                            end
                            if (reading < int'(peak_min[axis])) begin
                                peak_min[axis] = VAL_W'(reading);
                            end
                        end
                    end
                    // Integer division truncates toward zero, as the offset does.
                    offset = (int'(peak_max[axis]) + int'(peak_min[axis])) / 2;
                    due[CORR_W*axis +: CORR_W]           = CORR_W'(used - offset);
                    due[OFF_LSB + VAL_W*axis +: VAL_W]   = VAL_W'(offset);
                    due[FROZEN_LSB + axis] =
                        (int'(peak_max[axis]) - int'(peak_min[axis]) >= int'(span_limit));
                end
                corrected_samples_due.push_back(due);
            end

            // Compare each result transfer with the oldest prediction.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (corrected_samples_due.size() == 0) begin
                    $display("%0t: result with no sample outstanding: expected none, got %h",
                             $time, got);
                    mismatches++;
                end else begin
                    due = corrected_samples_due.pop_front();
                    for (axis = 0; axis < AXES; axis++) begin
                        if (got[CORR_W*axis +: CORR_W] !== due[CORR_W*axis +: CORR_W]) begin
                            $display("%0t: corr_%s expected %0d, got %0d", $time,
                                     axis_tag[axis],
                                     $signed(due[CORR_W*axis +: CORR_W]),
                                     $signed(got[CORR_W*axis +: CORR_W]));
                            mismatches++;
                        end
                        if (got[OFF_LSB + VAL_W*axis +: VAL_W]
                            !== due[OFF_LSB + VAL_W*axis +: VAL_W]) begin
                            $display("%0t: off_%s expected %0d, got %0d", $time,
                                     axis_tag[axis],
                                     $signed(due[OFF_LSB + VAL_W*axis +: VAL_W]),
                                     $signed(got[OFF_LSB + VAL_W*axis +: VAL_W]));
                            mismatches++;
                        end
                        if (got[FROZEN_LSB + axis] !== due[FROZEN_LSB + axis]) begin
                            $display("%0t: frozen_%s expected %0b, got %0b", $time,
                                     axis_tag[axis], due[FROZEN_LSB + axis],
                                     got[FROZEN_LSB + axis]);
                            mismatches++;
                        end
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_results_due    <= corrected_samples_due.size();
    end

endmodule

>>> tb/magnetometer_offset_calibration_tb.sv
// Testbench top for the magnetometer offset calibration block.
// Drives samples and register writes, stalls the result side and gives the verdict;
// depends on mocal_pkg, magnetometer_offset_calibration and mocal_checker.
`timescale 1ns / 1ps

module magnetometer_offset_calibration_tb;
    import mocal_pkg::*;

    localparam int unsigned PHASES        = 10;
    localparam int unsigned PHASE_SAMPLES = 143;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_REJECT_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    int                    mismatch_count;
    int                    results_due;
    int                    burst_left      = 0;
    t_stall_mode           stall_mode      = STALL_NONE;
    int                    stall_run       = 0;

    // Spike limit and freeze span of each random phase; negative means random.
    int phase_limit [PHASES] = '{200, 500,   60, 1000, 2047,    0, 1500, -1, 2047, -1};
    int phase_span  [PHASES] = '{300, 1000, 1500, 2000,   0, 4095, 3000, -1, 4095, -1};

    magnetometer_offset_calibration dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    mocal_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: the stall pattern is redrawn at random whenever its run counter runs out.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(STALL_NONE, STALL_TOGGLE));
            stall_run  <= $urandom_range(8, 64);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_NONE:   i_m_axis_tready <= 1'b1;
            STALL_HALF:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            STALL_HEAVY:  i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            STALL_TOGGLE: i_m_axis_tready <= !i_m_axis_tready;
            default:      i_m_axis_tready <= 1'b1;
        endcase
    end

    // Mostly in-range readings, with the limits, just past them, zero and full-range noise.
    function automatic int pick_reading(int lim);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return int'($urandom_range(0, 2 * lim)) - lim;
        end else if (roll < 70) begin
            return ($urandom_range(0, 1) != 0) ? lim : -lim;
        end else if (roll < 78) begin
            return ($urandom_range(0, 1) != 0) ? lim + 1 : -(lim + 1);
        end else if (roll < 82) begin
            return 0;
        end else begin
            return int'($urandom_range(0, 65535)) - 32768;
        end
    endfunction

    // One sample transfer; the sender pauses between bursts of random length.
    task automatic send_sample(int x, int y, int z);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {RAW_W'(z), RAW_W'(y), RAW_W'(x)};
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic set_limits(int lim, int span);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_REJECT_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(lim);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_FREEZE_SPAN;
        i_cfg_data  <= CFG_DATA_W'(span);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int lim;
        int span;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero freeze span from reset: nothing tracked, spikes replaced by zero.
        set_limits(2047, 0);
        send_sample(100, -100, 0);
        send_sample(3000, -32768, 2047);
        send_sample(-2047, 2048, 32767);
        send_sample(1, -1, -2048);

        // Readings at and just past the limit, freezing, and one item overshooting the span.
        set_limits(120, 120);
        send_sample(32767, -32768, -121);
        send_sample(120, -120, 121);
        send_sample(-60, 60, 50);
        send_sample(500, -500, -100);
        send_sample(0, 0, 30);
        send_sample(-32768, 32767, -32768);

        // Zero reject limit: only zero gets through.
        set_limits(0, 4095);
        send_sample(0, 0, 0);
        send_sample(1, -1, 2047);
        send_sample(0, -32768, 0);

        // Widest limits.
        set_limits(2047, 4095);
        send_sample(2047, -2047, 0);
        send_sample(-2047, 2047, 2048);
        send_sample(-2048, -2047, 1000);

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            lim  = (phase_limit[p] < 0) ? $urandom_range(1, 2047) : phase_limit[p];
            span = (phase_span[p] < 0) ? $urandom_range(1, 4095) : phase_span[p];
            set_limits(lim, span);
            repeat (PHASE_SAMPLES) begin
                send_sample(pick_reading(lim), pick_reading(lim), pick_reading(lim));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
